/* design/cec_pkg.sv */
// shared constants, state encoding and calendar helpers for the epoch converter
package cec_pkg;

  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [31:0] SecsPerHour = 32'd3600;
  localparam logic [31:0] SecsPerMin  = 32'd60;
  localparam logic [11:0] BaseYear    = 12'd2000;
  localparam logic [11:0] EpochYear   = 12'd1970;
  localparam logic [11:0] SkipLeapYear = 12'd2100;
  // reciprocals of 675, 225 and 15 scaled by 2^35, 2^21 and 2^14
  localparam logic [25:0] RecipDay    = 26'd50903317;
  localparam logic [13:0] RecipHour   = 14'd9321;
  localparam logic [10:0] RecipMin    = 11'd1093;
  localparam logic [3:0]  LastMonIdx  = 4'd11;
  localparam logic [3:0]  MaxMonth    = 4'd12;

  typedef enum logic [0:0] {
    OP_TO_EPOCH = 1'b0,
    OP_TO_CAL   = 1'b1
  } op_e;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'b0000000000000001,
    ST_C_YEAR = 16'b0000000000000010,
    ST_C_MON  = 16'b0000000000000100,
    ST_C_DAY  = 16'b0000000000001000,
    ST_C_HOUR = 16'b0000000000010000,
    ST_C_MIN  = 16'b0000000000100000,
    ST_C_SEC  = 16'b0000000001000000,
    ST_S_DIV  = 16'b0000000010000000,
    ST_S_REM  = 16'b0000000100000000,
    ST_S_YEAR = 16'b0000001000000000,
    ST_S_MON  = 16'b0000010000000000,
    ST_S_HOUR = 16'b0000100000000000,
    ST_S_HREM = 16'b0001000000000000,
    ST_S_MIN  = 16'b0010000000000000,
    ST_S_MREM = 16'b0100000000000000,
    ST_FIN    = 16'b1000000000000000
  } state_e;

  // gregorian rule, exact for years 1901 to 2199
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != SkipLeapYear);
  endfunction

  function automatic logic [8:0] year_len(input logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len + {4'd0, (idx == 4'd1) && leap};
  endfunction

  function automatic logic [31:0] day_secs(input logic [8:0] d);
    return 32'({23'd0, d} * SecsPerDay);
  endfunction

endpackage

/* design/calendar_epoch_converter_core.sv */
// calendar time to unix epoch seconds converter, both directions
//
// usage: drive op_i and the input fields and raise start_i while busy_o is
// low; the beat is taken at that clock edge and busy_o rises. op 0 packs
// year/month/day/hour/minute/second into epoch seconds, op 1 splits epoch
// seconds into calendar fields. fields not produced by the op read zero.
// the result shows on the output ports for one cycle with valid_o high;
// the receiver cannot stall, so it must take the beat in that cycle.
// one shared 32-bit add/subtract unit does the walks and the remainders
// under a sequencer; busy_o stays high while op 0 walks the years from 1970
// and the months, then adds day, hour, minute and second, and while op 1
// divides out the days, walks the years and months from 1970, then splits
// out hours, minutes and seconds.
// the year walk is the long part; valid_o follows in the next cycle, and a
// new beat can be started in the cycle valid_o is high. reset clears the
// sequencer and the strobe at once and the block is idle right after reset.
module calendar_epoch_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [31:0] epoch_in_i,
  input  logic [6:0]  year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  output logic        valid_o,
  output logic [31:0] epoch_out_o,
  output logic [7:0]  year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o
);
  import cec_pkg::*;

  state_e      state_q, state_d;
  logic        valid_q, valid_d;
  op_e         op_q, op_d;
  logic [31:0] acc_q, acc_d;
  logic [16:0] rem_q, rem_d;
  logic [11:0] y_q, y_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [6:0]  year_in_q, year_in_d;
  logic [3:0]  month_in_q, month_in_d;
  logic [4:0]  day_in_q, day_in_d;
  logic [4:0]  hour_in_q, hour_in_d;
  logic [5:0]  minute_in_q, minute_in_d;
  logic [5:0]  second_in_q, second_in_d;
  logic [31:0] epoch_out_q, epoch_out_d;
  logic [7:0]  year_out_q, year_out_d;
  logic [3:0]  month_out_q, month_out_d;
  logic [4:0]  day_out_q, day_out_d;
  logic [4:0]  hour_out_q, hour_out_d;
  logic [5:0]  minute_out_q, minute_out_d;
  logic [5:0]  second_out_q, second_out_d;

  // shared add/subtract unit
  logic [31:0] opa, opb;
  logic        sub;
  logic [32:0] sum;
  logic        no_borrow;
  logic [11:0] target_year;
  logic        leap;
  logic [3:0]  mon_idx;

  // reciprocal quotients for days, hours and minutes
  logic [50:0] day_prod;
  logic [25:0] hour_prod;
  logic [19:0] min_prod;

  assign sum       = {1'b0, opa} + {1'b0, sub ? ~opb : opb} + {32'd0, sub};
  assign no_borrow = sum[32];
  assign target_year = BaseYear + {5'd0, year_in_q};
  assign leap      = is_leap(y_q);
  assign mon_idx   = (op_q == OP_TO_CAL) ? mon_q : mon_q - 4'd1;

  assign day_prod  = {26'd0, acc_q[31:7]} * {25'd0, RecipDay};
  assign hour_prod = {13'd0, rem_q[16:4]} * {12'd0, RecipHour};
  assign min_prod  = {10'd0, rem_q[11:2]} * {9'd0, RecipMin};

  always_comb begin
    opa = acc_q;
    opb = 32'd0;
    sub = 1'b0;
    unique case (state_q)
      ST_C_YEAR: opb = day_secs(year_len(y_q));
      ST_C_MON:  opb = day_secs({4'd0, month_len(mon_idx, leap)});
      ST_C_DAY:  opb = day_secs({4'd0, day_in_q});
      ST_C_HOUR: opb = 32'({27'd0, hour_in_q} * SecsPerHour);
      ST_C_MIN:  opb = 32'({26'd0, minute_in_q} * SecsPerMin);
      ST_C_SEC:  opb = {26'd0, second_in_q};
      ST_S_REM: begin
        opa = {15'd0, rem_q};
        opb = 32'({16'd0, acc_q[15:0]} * SecsPerDay);
        sub = 1'b1;
      end
      ST_S_YEAR: begin
        opb = {23'd0, year_len(y_q)};
        sub = 1'b1;
      end
      ST_S_MON: begin
        opb = {27'd0, month_len(mon_idx, leap)};
        sub = 1'b1;
      end
      ST_S_HREM: begin
        opa = {15'd0, rem_q};
        opb = 32'({27'd0, hour_q} * SecsPerHour);
        sub = 1'b1;
      end
      ST_S_MREM: begin
        opa = {15'd0, rem_q};
        opb = 32'({26'd0, min_q} * SecsPerMin);
        sub = 1'b1;
      end
      default: begin
        opa = acc_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = 1'b0;
    op_d         = op_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    y_d          = y_q;
    mon_d        = mon_q;
    hour_d       = hour_q;
    min_d        = min_q;
    year_in_d    = year_in_q;
    month_in_d   = month_in_q;
    day_in_d     = day_in_q;
    hour_in_d    = hour_in_q;
    minute_in_d  = minute_in_q;
    second_in_d  = second_in_q;
    epoch_out_d  = epoch_out_q;
    year_out_d   = year_out_q;
    month_out_d  = month_out_q;
    day_out_d    = day_out_q;
    hour_out_d   = hour_out_q;
    minute_out_d = minute_out_q;
    second_out_d = second_out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d        = op_e'(op_i);
          year_in_d   = year_in_i;
          month_in_d  = month_in_i;
          day_in_d    = day_in_i;
          hour_in_d   = hour_in_i;
          minute_in_d = minute_in_i;
          second_in_d = second_in_i;
          y_d         = EpochYear;
          rem_d       = 17'd0;
          if (op_i == OP_TO_CAL) begin
            acc_d   = epoch_in_i;
            mon_d   = 4'd0;
            state_d = ST_S_DIV;
          end else begin
            // day counts from one, so start one day below zero
            acc_d   = 32'd0 - SecsPerDay;
            mon_d   = 4'd1;
            state_d = ST_C_YEAR;
          end
        end
      end
      ST_C_YEAR: begin
        if (y_q < target_year) begin
          acc_d = sum[31:0];
          y_d   = y_q + 12'd1;
        end else begin
          state_d = ST_C_MON;
        end
      end
      ST_C_MON: begin
        if ((mon_q < month_in_q) && (mon_q <= MaxMonth)) begin
          acc_d = sum[31:0];
          mon_d = mon_q + 4'd1;
        end else begin
          state_d = ST_C_DAY;
        end
      end
      ST_C_DAY: begin
        acc_d   = sum[31:0];
        state_d = ST_C_HOUR;
      end
      ST_C_HOUR: begin
        acc_d   = sum[31:0];
        state_d = ST_C_MIN;
      end
      ST_C_MIN: begin
        acc_d   = sum[31:0];
        state_d = ST_C_SEC;
      end
      ST_C_SEC: begin
        acc_d   = sum[31:0];
        state_d = ST_FIN;
      end
      ST_S_DIV: begin
        // days from epoch / 128 / 675, low epoch bits kept for the remainder
        acc_d   = {16'd0, day_prod[50:35]};
        rem_d   = acc_q[16:0];
        state_d = ST_S_REM;
      end
      ST_S_REM: begin
        rem_d   = sum[16:0];
        state_d = ST_S_YEAR;
      end
      ST_S_YEAR: begin
        if (no_borrow) begin
          acc_d = sum[31:0];
          y_d   = y_q + 12'd1;
        end else begin
          state_d = ST_S_MON;
        end
      end
      ST_S_MON: begin
        if (no_borrow && (mon_q < LastMonIdx)) begin
          acc_d = sum[31:0];
          mon_d = mon_q + 4'd1;
        end else begin
          state_d = ST_S_HOUR;
        end
      end
      ST_S_HOUR: begin
        hour_d  = hour_prod[25:21];
        state_d = ST_S_HREM;
      end
      ST_S_HREM: begin
        rem_d   = sum[16:0];
        state_d = ST_S_MIN;
      end
      ST_S_MIN: begin
        min_d   = min_prod[19:14];
        state_d = ST_S_MREM;
      end
      ST_S_MREM: begin
        rem_d   = sum[16:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (op_q == OP_TO_CAL) begin
          epoch_out_d  = 32'd0;
          year_out_d   = 8'(y_q - BaseYear);
          month_out_d  = mon_q + 4'd1;
          day_out_d    = acc_q[4:0] + 5'd1;
          hour_out_d   = hour_q;
          minute_out_d = min_q;
          second_out_d = rem_q[5:0];
        end else begin
          epoch_out_d  = acc_q;
          year_out_d   = 8'd0;
          month_out_d  = 4'd0;
          day_out_d    = 5'd0;
          hour_out_d   = 5'd0;
          minute_out_d = 6'd0;
          second_out_d = 6'd0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    acc_q        <= acc_d;
    rem_q        <= rem_d;
    y_q          <= y_d;
    mon_q        <= mon_d;
    hour_q       <= hour_d;
    min_q        <= min_d;
    year_in_q    <= year_in_d;
    month_in_q   <= month_in_d;
    day_in_q     <= day_in_d;
    hour_in_q    <= hour_in_d;
    minute_in_q  <= minute_in_d;
    second_in_q  <= second_in_d;
    epoch_out_q  <= epoch_out_d;
    year_out_q   <= year_out_d;
    month_out_q  <= month_out_d;
    day_out_q    <= day_out_d;
    hour_out_q   <= hour_out_d;
    minute_out_q <= minute_out_d;
    second_out_q <= second_out_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign epoch_out_o  = epoch_out_q;
  assign year_out_o   = year_out_q;
  assign month_out_o  = month_out_q;
  assign day_out_o    = day_out_q;
  assign hour_out_o   = hour_out_q;
  assign minute_out_o = minute_out_q;
  assign second_out_o = second_out_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not make the block busy");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_HOUR) |-> (rem_q < SecsPerDay[16:0]))
    else $error("time of day remainder out of range");

endmodule
